[hdl/fss_pkg.sv]
// Package for the filtered sparse set: sizes, op and register codes,
// the result record and the controller/datapath command and status groups.
// No dependencies.
package fss_pkg;

  localparam int MAX_ENTITIES = 1024;
  localparam int ID_W         = $clog2(MAX_ENTITIES);
  localparam int CNT_W        = ID_W + 1;
  localparam int COMP_W       = 64;
  localparam int ANY_GROUPS   = 4;
  localparam int GRP_W        = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int OP_W         = 3;

  // Operation codes carried in the input beat
  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_CHK_INSERT = 3'd1,
    OP_CHK_REMOVE = 3'd2,
    OP_REMOVE     = 3'd3,
    OP_READ       = 3'd4
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WITH     = 3'd0,
    CFG_WITHOUT  = 3'd1,
    CFG_ANY_CNT  = 3'd2,
    CFG_ANY_A    = 3'd3,
    CFG_ANY_B    = 3'd4,
    CFG_ANY_C    = 3'd5,
    CFG_ANY_D    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_FIX,
    ST_EMIT
  } state_e;

  // Sparse map entry
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] slot;
  } sp_entry_t;

  // Result record, filter_pass in the lowest bit
  typedef struct packed {
    logic             read_valid;
    logic [ID_W-1:0]  read_entity;
    logic [CNT_W-1:0] member_count;
    logic [ID_W-1:0]  slot;
    logic             is_member;
    logic             changed;
    logic             filter_pass;
  } result_t;

  localparam int RES_W      = $bits(result_t);
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic cap;
    logic decide;
    logic fix;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic swap;
    logic out_free;
  } stat_t;

endpackage

[hdl/fss_filter.sv]
// Configuration registers and the component bitmask filter.
// Depends on fss_pkg.
module fss_filter
  import fss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [COMP_W-1:0]     bits_i,
  output logic                  pass_o
);

  logic [COMP_W-1:0] with_q, without_q;
  logic [GRP_W-1:0]  grp_q;
  logic [COMP_W-1:0] any_q [ANY_GROUPS];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      with_q    <= '0;
      without_q <= '0;
      grp_q     <= '0;
      for (int i = 0; i < ANY_GROUPS; i++) any_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WITH:    with_q    <= cfg_wdata_i[COMP_W-1:0];
        CFG_WITHOUT: without_q <= cfg_wdata_i[COMP_W-1:0];
        CFG_ANY_CNT: grp_q     <= cfg_wdata_i[GRP_W-1:0];
        CFG_ANY_A:   any_q[0]  <= cfg_wdata_i[COMP_W-1:0];
        CFG_ANY_B:   any_q[1]  <= cfg_wdata_i[COMP_W-1:0];
        CFG_ANY_C:   any_q[2]  <= cfg_wdata_i[COMP_W-1:0];
        CFG_ANY_D:   any_q[3]  <= cfg_wdata_i[COMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Filter: all with bits, no without bits, a hit in every active group.
  // A group count above the group total enables all groups.
  logic any_ok;
  always_comb begin
    any_ok = 1'b1;
    for (int i = 0; i < ANY_GROUPS; i++) begin
      if (grp_q > GRP_W'(i) && (bits_i & any_q[i]) == '0) any_ok = 1'b0;
    end
  end

  assign pass_o = any_ok && ((bits_i & with_q) == with_q) && ((bits_i & without_q) == '0);

endmodule

[hdl/fss_ctrl.sv]
// Controller state machine for the sparse set: clear sweep, accept,
// decide/write, swap fix-up and result hand-off. Depends on fss_pkg.
module fss_ctrl
  import fss_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (stat_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_DECIDE;
      ST_DECIDE: state_d = stat_i.swap ? ST_FIX : ST_EMIT;
      ST_FIX:    state_d = ST_EMIT;
      ST_EMIT:   if (stat_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR:  cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.cap  = in_valid_i;
      end
      ST_DECIDE: cmd_o.decide = 1'b1;
      ST_FIX:    cmd_o.fix    = 1'b1;
      ST_EMIT:   cmd_o.emit   = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

[hdl/fss_datapath.sv]
// Datapath: sparse map and dense id memories, member count, item
// registers, result holding register and output register. Depends on fss_pkg.
module fss_datapath
  import fss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [ID_W-1:0]   id_i,
  input  logic [COMP_W-1:0] bits_i,
  input  logic [ID_W-1:0]   rslot_i,
  input  logic              pass_i,
  output logic [COMP_W-1:0] bits_o,
  output result_t           out_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);

  // Item registers
  logic [OP_W-1:0]   op_q;
  logic [ID_W-1:0]   id_q, rslot_q;
  logic [COMP_W-1:0] bits_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q    <= op_i;
      id_q    <= id_i;
      bits_q  <= bits_i;
      rslot_q <= rslot_i;
    end
  end
  assign bits_o = bits_q;

  // Member count and clear sweep address
  logic [CNT_W-1:0] count_q, count_d;
  logic [ID_W-1:0]  clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      clr_addr_q <= '0;
    end else begin
      if (cmd_i.decide) count_q <= count_d;
      if (cmd_i.clr_wr) clr_addr_q <= clr_addr_q + ID_W'(1);
    end
  end
  assign stat_o.clr_last = (clr_addr_q == ID_W'(MAX_ENTITIES - 1));

  // Memories: reads issued at accept, addressed from the beat, the last-slot read from the member count
  sp_entry_t       sparse_mem [MAX_ENTITIES];
  logic [ID_W-1:0] dense_mem  [MAX_ENTITIES];
  sp_entry_t       sp_rd_q;
  logic [ID_W-1:0] dn_rd_slot_q, dn_rd_last_q;
  logic [ID_W-1:0] last_slot;

  assign last_slot = count_q[ID_W-1:0] - ID_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      sp_rd_q      <= sparse_mem[id_i];
      dn_rd_slot_q <= dense_mem[rslot_i];
      dn_rd_last_q <= dense_mem[last_slot];
    end
  end

  // Decision logic on the looked-up entry
  logic is_ins, is_rem, do_ins, do_rem, swap, ins_op, rvalid, member;
  result_t res;

  always_comb begin
    ins_op = (op_q == OP_INSERT) || (op_q == OP_CHK_INSERT);
    is_ins = (op_q == OP_INSERT) || (op_q == OP_CHK_INSERT && pass_i);
    is_rem = (op_q == OP_REMOVE) || (op_q == OP_CHK_REMOVE && !pass_i);
    do_ins = is_ins && !sp_rd_q.valid && (count_q != CNT_W'(MAX_ENTITIES));
    do_rem = is_rem && sp_rd_q.valid && (count_q != '0);
    swap   = do_rem && (sp_rd_q.slot != last_slot);
    rvalid = (op_q == OP_READ) && ({1'b0, rslot_q} < count_q);

    priority if (do_ins)      count_d = count_q + CNT_W'(1);
    else if (do_rem)          count_d = count_q - CNT_W'(1);
    else                      count_d = count_q;

    priority if (do_ins)      member = 1'b1;
    else if (do_rem)          member = 1'b0;
    else                      member = sp_rd_q.valid;

    res.filter_pass  = pass_i;
    res.changed      = do_ins || do_rem;
    res.is_member    = member;
    res.slot         = (ins_op && member) ? (do_ins ? count_q[ID_W-1:0] : sp_rd_q.slot) : '0;
    res.member_count = count_d;
    res.read_entity  = rvalid ? dn_rd_slot_q : '0;
    res.read_valid   = rvalid;
  end
  assign stat_o.swap = swap;

  // Sparse map write port: clear, insert, swap fix of moved id, free of removed id
  logic            sp_we, dn_we;
  logic [ID_W-1:0] sp_waddr, dn_waddr, dn_wdata;
  sp_entry_t       sp_wdata;

  always_comb begin
    sp_we    = 1'b0;
    sp_waddr = id_q;
    sp_wdata = '0;
    dn_we    = 1'b0;
    dn_waddr = count_q[ID_W-1:0];
    dn_wdata = id_q;
    priority if (cmd_i.clr_wr) begin
      sp_we    = 1'b1;
      sp_waddr = clr_addr_q;
    end else if (cmd_i.fix) begin
      sp_we    = 1'b1;
    end else if (cmd_i.decide) begin
      if (do_ins) begin
        sp_we          = 1'b1;
        sp_wdata.valid = 1'b1;
        sp_wdata.slot  = count_q[ID_W-1:0];
        dn_we          = 1'b1;
      end else if (swap) begin
        // last entry moves into the hole; its map entry points there
        sp_we          = 1'b1;
        sp_waddr       = dn_rd_last_q;
        sp_wdata.valid = 1'b1;
        sp_wdata.slot  = sp_rd_q.slot;
        dn_we          = 1'b1;
        dn_waddr       = sp_rd_q.slot;
        dn_wdata       = dn_rd_last_q;
      end else if (do_rem) begin
        sp_we          = 1'b1;
      end
    end else begin
      // idle or hand-off: no memory write
    end
  end

  always_ff @(posedge clk_i) begin
    if (sp_we) sparse_mem[sp_waddr] <= sp_wdata;
    if (dn_we) dense_mem[dn_waddr]  <= dn_wdata;
  end

  // Result holding register, then output register toward the master side
  result_t res_q, out_q;
  logic    out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) res_q <= res;
    if (cmd_i.emit)   out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          out_valid_q <= 1'b0;
    else if (cmd_i.emit)  out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_o           = out_q;
  assign out_valid_o     = out_valid_q;

endmodule

[hdl/filtered_sparse_set.sv]
// Top level of the filtered sparse set: stream ports, configuration port,
// and the controller, datapath and filter. Depends on fss_pkg and all fss_* modules.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata 88b, tuser 3b (op)
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata 40b
//  cfg       in   cfg_we_i                       cfg_idx_i 3b, cfg_wdata_i 64b
//
// An item passes through accept with memory reads, decide with the memory
// writes and hand-off to the output register. A remove that moves the last
// dense entry adds a fix-up step, as the sparse map has one write port and needs two writes.
// After reset a clearing pass writes all 1024 sparse map entries, one a cycle,
// and no item is accepted until it ends. The output register lets the next
// beat be accepted while a result waits; a stall holds an item only in its
// hand-off cycle.
module filtered_sparse_set
  import fss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // entity_id [9:0], component_bits [73:10], read_slot [83:74], zero pad
  input  logic [87:0]           s_axis_tdata,
  // op [2:0]
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // filter_pass [0], changed [1], is_member [2], slot [12:3],
  // member_count [23:13], read_entity [33:24], read_valid [34], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cmd_t              cmd;
  stat_t             stat;
  logic              pass;
  logic [COMP_W-1:0] bits_q;
  result_t           out_res;

  fss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fss_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .bits_i      (bits_q),
    .pass_o      (pass)
  );

  fss_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (s_axis_tuser),
    .id_i        (s_axis_tdata[ID_W-1:0]),
    .bits_i      (s_axis_tdata[ID_W+COMP_W-1:ID_W]),
    .rslot_i     (s_axis_tdata[2*ID_W+COMP_W-1:ID_W+COMP_W]),
    .pass_i      (pass),
    .bits_o      (bits_q),
    .out_o       (out_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - RES_W){1'b0}}, out_res};

endmodule

[dv/tb_top.sv]
// Self-checking testbench for filtered_sparse_set: stream stimulus, random back-pressure
// and a scoreboard that predicts every result beat from its own copy of the set.
// Depends on fss_pkg and the filtered_sparse_set RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fss_pkg::*;

  // Unnamed op codes, which must leave the set untouched
  localparam logic [OP_W-1:0] OP_SPARE_LO = OP_W'(OP_READ + 1);
  localparam logic [OP_W-1:0] OP_SPARE_HI = '1;
  localparam logic [COMP_W-1:0] ALL_ONES = '1;
  localparam int SMALL_POOL = 48;

  // Predicts each result from the accepted input beats and checks the output beats
  class sparse_set_scoreboard;
    logic [COMP_W-1:0] with_m;
    logic [COMP_W-1:0] without_m;
    logic [GRP_W-1:0]  grp_cnt;
    logic [COMP_W-1:0] any_m[ANY_GROUPS];
    bit                in_set[MAX_ENTITIES];
    logic [ID_W-1:0]   slot_of[MAX_ENTITIES];
    logic [ID_W-1:0]   dense[MAX_ENTITIES];
    int unsigned       members;
    result_t           expected_q[$];
    int unsigned       errors, beats, results, changes, peak, passes, read_hits;

    function new();
      with_m = '0;
      without_m = '0;
      grp_cnt = '0;
      foreach (any_m[g]) any_m[g] = '0;
      foreach (in_set[i]) begin
        in_set[i] = 1'b0;
        slot_of[i] = '0;
        dense[i] = '0;
      end
      members = 0;
      errors = 0;
      beats = 0;
      results = 0;
      changes = 0;
      peak = 0;
      passes = 0;
      read_hits = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_WITH:    with_m = v;
        CFG_WITHOUT: without_m = v;
        CFG_ANY_CNT: grp_cnt = v[GRP_W-1:0];
        CFG_ANY_A:   any_m[0] = v;
        CFG_ANY_B:   any_m[1] = v;
        CFG_ANY_C:   any_m[2] = v;
        CFG_ANY_D:   any_m[3] = v;
        default: ;
      endcase
    endfunction

    // Count above the number of groups saturates; an all-zero active group always fails
    function bit filter_ok(logic [COMP_W-1:0] bits);
      int groups;
      groups = (grp_cnt > ANY_GROUPS) ? ANY_GROUPS : grp_cnt;
      for (int g = 0; g < groups; g++)
        if ((bits & any_m[g]) == '0) return 1'b0;
      if ((bits & with_m) != with_m) return 1'b0;
      return (bits & without_m) == '0;
    endfunction

    function bit add_member(logic [ID_W-1:0] id);
      if (in_set[id] || members >= MAX_ENTITIES) return 1'b0;
      in_set[id] = 1'b1;
      slot_of[id] = ID_W'(members);
      dense[members] = id;
      members++;
      if (members > peak) peak = members;
      return 1'b1;
    endfunction

    // Swap-remove: the last dense entry fills the freed slot
    function bit drop_member(logic [ID_W-1:0] id);
      logic [ID_W-1:0] hole, moved;
      int unsigned last;
      if (!in_set[id] || members == 0) return 1'b0;
      hole = slot_of[id];
      last = members - 1;
      if (hole != last) begin
        moved = dense[last];
        dense[hole] = moved;
        slot_of[moved] = hole;
      end
      in_set[id] = 1'b0;
      slot_of[id] = '0;
      members--;
      return 1'b1;
    endfunction

    function void note_beat(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                            logic [COMP_W-1:0] bits, logic [ID_W-1:0] rslot);
      result_t r;
      bit pass, chg;
      r = '0;
      pass = filter_ok(bits);
      chg = 1'b0;
      case (op)
        OP_INSERT:     chg = add_member(id);
        OP_CHK_INSERT: if (pass) chg = add_member(id);
        OP_CHK_REMOVE: if (!pass) chg = drop_member(id);
        OP_REMOVE:     chg = drop_member(id);
        OP_READ: begin
          if (rslot < members) begin
            r.read_valid = 1'b1;
            r.read_entity = dense[rslot];
            read_hits++;
          end
        end
        default: ;
      endcase
      r.filter_pass = pass;
      r.changed = chg;
      r.is_member = in_set[id];
      if ((op == OP_INSERT || op == OP_CHK_INSERT) && in_set[id]) r.slot = slot_of[id];
      r.member_count = CNT_W'(members);
      expected_q.push_back(r);
      beats++;
      changes += chg;
      passes += pass;
    endfunction

    function void cmp_field(string name, logic [COMP_W-1:0] want_v, logic [COMP_W-1:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
      end
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat 0x%0h with no item outstanding", $time, got);
        return;
      end
      want = expected_q.pop_front();
      results++;
      cmp_field("filter_pass", want.filter_pass, got.filter_pass);
      cmp_field("changed", want.changed, got.changed);
      cmp_field("is_member", want.is_member, got.is_member);
      cmp_field("slot", want.slot, got.slot);
      cmp_field("member_count", want.member_count, got.member_count);
      cmp_field("read_entity", want.read_entity, got.read_entity);
      cmp_field("read_valid", want.read_valid, got.read_valid);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // entity_id [9:0], component_bits [73:10], read_slot [83:74], zero pad
  logic [87:0]           s_axis_tdata;
  // op [2:0]
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // filter_pass [0], changed [1], is_member [2], slot [12:3],
  // member_count [23:13], read_entity [33:24], read_valid [34], zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  sparse_set_scoreboard sb;
  int burst_left;
  int filter_settings;

  filtered_sparse_set dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: ready runs and stalls of random length, now and then a long open stretch
  initial begin
    int ready_run, stall_run;
    m_axis_tready = 1'b0;
    forever begin
      if ($urandom_range(0, 5) == 0) begin
        ready_run = 200;
        stall_run = 0;
      end else begin
        ready_run = $urandom_range(1, 20);
        stall_run = $urandom_range(0, 8);
      end
      repeat (ready_run) begin
        @(negedge clk_i);
        m_axis_tready = 1'b1;
      end
      repeat (stall_run) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
    end
  end

  // Output beat monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_beat(result_t'(m_axis_tdata[RES_W-1:0]));
  end

  // Run limit
  initial begin
    #(20_000_000);
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [COMP_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [COMP_W-1:0] sparse64();
    return rand64() & rand64();
  endfunction

  // Seven times in ten a contended small pool so ops hit members; wide picks use the full range
  function automatic logic [ID_W-1:0] pick_id(bit wide);
    if (wide || $urandom_range(0, 9) < 3) return ID_W'($urandom_range(0, MAX_ENTITIES - 1));
    return ID_W'($urandom_range(0, SMALL_POOL - 1));
  endfunction

  function automatic logic [ID_W-1:0] pick_slot();
    if (sb.members > 0 && $urandom_range(0, 2) != 0)
      return ID_W'($urandom_range(0, sb.members - 1));
    return ID_W'($urandom_range(0, MAX_ENTITIES - 1));
  endfunction

  // Mostly bitmasks built to sit on the pass/fail boundary of the current filter
  function automatic logic [COMP_W-1:0] make_bits();
    logic [COMP_W-1:0] b, m;
    int groups;
    if ($urandom_range(0, 2) == 0) return rand64();
    groups = (sb.grp_cnt > ANY_GROUPS) ? ANY_GROUPS : sb.grp_cnt;
    b = (rand64() & ~sb.without_m) | sb.with_m;
    for (int g = 0; g < groups; g++) begin
      m = sb.any_m[g];
      b |= m & (~m + 1'b1);
    end
    if ($urandom_range(0, 3) == 0) b ^= ALL_ONES & (64'h1 << $urandom_range(0, COMP_W - 1));
    return b;
  endfunction

  // Sender: bursts of random length separated by random gaps
  task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                           logic [COMP_W-1:0] bits, logic [ID_W-1:0] rslot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {4'b0, rslot, bits, id};
    s_axis_tuser = op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(op, id, bits, rslot);
  endtask

  // Stop sending and wait until every result is out and the block has settled
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic load_filter(logic [COMP_W-1:0] w, logic [COMP_W-1:0] wo,
                             logic [GRP_W-1:0] cnt, logic [COMP_W-1:0] a,
                             logic [COMP_W-1:0] b, logic [COMP_W-1:0] c,
                             logic [COMP_W-1:0] d);
    drain();
    write_reg(CFG_WITH, w);
    write_reg(CFG_WITHOUT, wo);
    write_reg(CFG_ANY_CNT, CFG_DATA_W'(cnt));
    write_reg(CFG_ANY_A, a);
    write_reg(CFG_ANY_B, b);
    write_reg(CFG_ANY_C, c);
    write_reg(CFG_ANY_D, d);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    filter_settings++;
  endtask

  // Random op mix; the shrink mix favors removes and spreads ids over the whole range
  task automatic run_phase(int n, bit shrink, bit pause_mid);
    logic [OP_W-1:0] op;
    int w;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) drain();
      w = $urandom_range(0, 99);
      if (w < 3) op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else if (w < (shrink ? 13 : 28)) op = OP_INSERT;
      else if (w < (shrink ? 23 : 50)) op = OP_CHK_INSERT;
      else if (w < (shrink ? 48 : 65)) op = OP_CHK_REMOVE;
      else if (w < 83) op = OP_REMOVE;
      else op = OP_READ;
      send_item(op, pick_id(shrink), make_bits(), pick_slot());
    end
  endtask

  initial begin
    int order[MAX_ENTITIES];
    int j, t;
    sb = new();
    burst_left = 0;
    filter_settings = 1;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_INSERT;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_WITH;
    cfg_wdata_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset filter passes everything: edge ids, duplicate insert, swap on remove,
    // remove of the last entry and of a non-member, reads past the count, spare ops
    send_item(OP_INSERT, '0, '0, '0);
    send_item(OP_INSERT, '1, ALL_ONES, '1);
    send_item(OP_INSERT, '0, ALL_ONES, '0);
    send_item(OP_READ, 10'd5, '0, '0);
    send_item(OP_READ, 10'd5, '0, 10'd1);
    send_item(OP_READ, 10'd5, '0, 10'd2);
    send_item(OP_READ, '1, ALL_ONES, '1);
    send_item(OP_REMOVE, 10'd5, '0, '0);
    send_item(OP_REMOVE, '0, '0, '0);
    send_item(OP_READ, '0, '0, '0);
    send_item(OP_REMOVE, '1, '0, '0);
    send_item(OP_REMOVE, '1, ALL_ONES, '0);
    send_item(OP_SPARE_LO, 10'd7, ALL_ONES, '1);
    send_item(OP_SPARE_HI, '1, ALL_ONES, '0);

    // One any-group: each filter term failing on its own, checked remove both ways
    load_filter(64'h1, 64'h8000_0000_0000_0000, 3'd1, 64'hF0, '0, '0, '0);
    send_item(OP_CHK_INSERT, 10'd3, 64'h11, '0);
    send_item(OP_CHK_INSERT, 10'd4, 64'h01, '0);
    send_item(OP_CHK_INSERT, 10'd5, 64'h8000_0000_0000_0011, '0);
    send_item(OP_CHK_INSERT, 10'd6, 64'h10, '0);
    send_item(OP_CHK_REMOVE, 10'd3, 64'h11, '0);
    send_item(OP_CHK_REMOVE, 10'd3, 64'h0, '0);
    send_item(OP_W'(OP_SPARE_LO + 1), 10'd3, 64'h11, '0);
    send_item(OP_READ, 10'd3, '0, '0);

    // Oversized group count with an empty fourth group: the filter can never pass
    load_filter('0, '0, '1, ALL_ONES, ALL_ONES, ALL_ONES, '0);
    send_item(OP_CHK_INSERT, 10'd9, ALL_ONES, '0);
    send_item(OP_INSERT, 10'd9, ALL_ONES, '0);
    send_item(OP_CHK_REMOVE, 10'd9, ALL_ONES, '0);

    // Random phases under a range of filters
    begin
      logic [COMP_W-1:0] wm;
      wm = sparse64();
      load_filter(wm, sparse64() & ~wm, 3'd2, sparse64(), sparse64(), rand64(), rand64());
    end
    run_phase(150, 1'b0, 1'b1);
    load_filter(ALL_ONES, '0, 3'd4, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    run_phase(150, 1'b0, 1'b0);
    load_filter('0, ALL_ONES, 3'd0, rand64(), rand64(), rand64(), rand64());
    run_phase(150, 1'b0, 1'b0);

    // Fill the set to capacity with every id in shuffled order
    load_filter('0, '0, 3'd0, '0, '0, '0, '0);
    foreach (order[i]) order[i] = i;
    for (int i = MAX_ENTITIES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) send_item(OP_INSERT, ID_W'(order[i]), rand64(), pick_slot());

    // Shrink from full, then a filter whose third group is empty
    load_filter(64'h1 << $urandom_range(0, COMP_W - 1), sparse64() & sparse64(), 3'd5,
                rand64(), rand64(), rand64(), rand64());
    run_phase(300, 1'b1, 1'b0);
    load_filter('0, '0, 3'd3, rand64(), rand64(), '0, rand64());
    run_phase(150, 1'b0, 1'b0);

    drain();
    $display("Run covered %0d input beats and %0d result beats over %0d filter settings.",
             sb.beats, sb.results, filter_settings);
    $display("Membership changed %0d times, peak occupancy %0d, filter passed %0d, reads hit %0d.",
             sb.changes, sb.peak, sb.passes, sb.read_hits);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
